// File: rtl/core/hspc_pkg.sv
// Shared types and constants for the skin pixel classifier.
`default_nettype none
package hspc_pkg;
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_MIN_SAT  = 3'd0;
	localparam cfg_idx_t CFG_HUE_LOW  = 3'd1;
	localparam cfg_idx_t CFG_HUE_HIGH = 3'd2;
	localparam cfg_idx_t CFG_RATIO_LO = 3'd3;
	localparam cfg_idx_t CFG_RATIO_HI = 3'd4;

	localparam logic [7:0] RST_MIN_SAT  = 8'd50;
	localparam logic [7:0] RST_HUE_LOW  = 8'd14;
	localparam logic [7:0] RST_HUE_HIGH = 8'd165;
	localparam logic [7:0] RST_RATIO_LO = 8'd8;
	localparam logic [7:0] RST_RATIO_HI = 8'd48;

	// divider geometry: 8-bit quotient, numerator and divisor widths
	localparam int QUO_W = 8;
	localparam int NUM_W = 17;
	localparam int DEN_W = 10;

	typedef enum logic [1:0] {
		HUE_RED   = 2'd0,
		HUE_GREEN = 2'd1,
		HUE_BLUE  = 2'd2
	} hue_sel_t;

	typedef struct packed {
		logic [7:0] min_sat;
		logic [7:0] hue_low;
		logic [7:0] hue_high;
		logic [7:0] ratio_lo;
		logic [7:0] ratio_hi;
	} cfg_regs_t;
endpackage
`default_nettype wire

// File: rtl/core/hspc_ifs.sv
// Channel interfaces: pixel in, mask out, register writes.
`default_nettype none
interface hspc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic       frame_end;
	modport source (output valid, blue, green, red, frame_end, input ready);
	modport sink (input valid, blue, green, red, frame_end, output ready);
endinterface

interface hspc_mask_if;
	logic       valid;
	logic       ready;
	logic [7:0] mask_value;
	logic       is_skin;
	logic       frame_end_out;
	modport source (output valid, mask_value, is_skin, frame_end_out, input ready);
	modport sink (input valid, mask_value, is_skin, frame_end_out, output ready);
endinterface

interface hspc_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hls_skin_pixel_classifier_unit.sv
// Skin pixel classifier: BGR to HLS conversion, threshold tests, mask out.
//
// Usage:
//   pixel : valid/ready channel, one BGR pixel plus frame_end per transaction.
//   mask  : valid/ready channel, mask_value (255/0), is_skin, frame_end_out.
//   cfg   : register writes, always ready; index 0..4 selects min saturation,
//           hue low band top, hue high band bottom, ratio low, ratio high (Q4.4).
//           Other indexes are dropped. Write only while the pipe is empty.
// Throughput: one pixel per cycle while the output does not stall (see Stall). The
//   depth comes from the two 8-stage dividers (saturation and hue) that run
//   side by side, plus two front stages and one output stage.
// Stall: the whole pipe advances together; pixel.ready is low only while the
//   output register holds a result that mask.ready has not taken. Nothing is
//   dropped or repeated.
// Reset: pipe valid bits clear, registers return to 50, 14, 165, 8, 48.
`default_nettype none
module hls_skin_pixel_classifier_unit
	import hspc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	hspc_pix_if.sink    pixel,
	hspc_mask_if.source mask,
	hspc_cfg_if.sink    cfg
);
	cfg_regs_t cfg_q;
	logic      adv;
	logic      out_valid_q;

	assign adv         = !out_valid_q || mask.ready;
	assign pixel.ready = adv;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{min_sat: RST_MIN_SAT, hue_low: RST_HUE_LOW,
				hue_high: RST_HUE_HIGH, ratio_lo: RST_RATIO_LO, ratio_hi: RST_RATIO_HI};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MIN_SAT:  cfg_q.min_sat  <= cfg.data;
				CFG_HUE_LOW:  cfg_q.hue_low  <= cfg.data;
				CFG_HUE_HIGH: cfg_q.hue_high <= cfg.data;
				CFG_RATIO_LO: cfg_q.ratio_lo <= cfg.data;
				CFG_RATIO_HI: cfg_q.ratio_hi <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage 1: max, min, lightness, hue sector
	logic [7:0]        mx, mn, dd;
	logic [8:0]        sum;
	logic [7:0]        sden;
	logic signed [8:0] hnum;
	hue_sel_t          hsel;

	always_comb begin
		mx = pixel.red;
		mn = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx) mx = pixel.blue;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
		dd  = mx - mn;
		sum = 9'(mx) + 9'(mn);
		sden = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
		if (mx == pixel.red) begin
			hsel = HUE_RED;
			hnum = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
		end else if (mx == pixel.green) begin
			hsel = HUE_GREEN;
			hnum = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
		end else begin
			hsel = HUE_BLUE;
			hnum = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
		end
	end

	logic              v_s1;
	logic [7:0]        l_s1, d_s1, sden_s1;
	logic signed [8:0] hnum_s1;
	hue_sel_t          hsel_s1;
	logic              fe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= pixel.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			l_s1    <= 8'((10'(sum) + 10'd1) >> 1);
			d_s1    <= dd;
			sden_s1 <= sden;
			hnum_s1 <= hnum;
			hsel_s1 <= hsel;
			fe_s1   <= pixel.frame_end;
		end
	end

	// stage 2: divider operands
	logic [6:0]         base;
	logic [14:0]        base_d;
	logic signed [17:0] num_ext, x, xa;
	logic [15:0]        d180;

	always_comb begin
		case (hsel_s1)
			HUE_GREEN: base = 7'd60;
			HUE_BLUE:  base = 7'd120;
			default:   base = 7'd0;
		endcase
		base_d  = 15'(base) * 15'(d_s1);
		num_ext = 18'(hnum_s1);
		d180    = 16'(d_s1) * 16'd180;
		x       = num_ext * 18'sd30 + $signed(18'(base_d));
		xa      = (x < 0) ? x + $signed(18'(d180)) : x;
	end

	logic             v_s2;
	logic [NUM_W-1:0] snum_s2, hnum_s2;
	logic [DEN_W-1:0] sden_s2, hden_s2;
	logic [7:0]       l_s2;
	logic             zero_s2, fe_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			snum_s2 <= NUM_W'(d_s1) * NUM_W'(510) + NUM_W'(sden_s1);
			sden_s2 <= DEN_W'({sden_s1, 1'b0});
			hnum_s2 <= NUM_W'({xa[15:0], 1'b0}) + NUM_W'(d_s1);
			hden_s2 <= (d_s1 == 8'd0) ? DEN_W'(2) : DEN_W'({d_s1, 1'b0});
			l_s2    <= l_s1;
			zero_s2 <= (d_s1 == 8'd0);
			fe_s2   <= fe_s1;
		end
	end

	// dividers, with side data delayed alongside
	logic [QUO_W-1:0] sat_q, hue_q;

	hspc_div u_sat_div (.clk(clk), .en(adv), .num_i(snum_s2), .den_i(sden_s2),
		.quo_o(sat_q));
	hspc_div u_hue_div (.clk(clk), .en(adv), .num_i(hnum_s2), .den_i(hden_s2),
		.quo_o(hue_q));

	logic [QUO_W-1:0] vd_q;
	logic [7:0]       ld_q    [0:QUO_W-1];
	logic             zerod_q [0:QUO_W-1];
	logic             fed_q   [0:QUO_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd_q <= '0;
		else if (adv) vd_q <= {vd_q[QUO_W-2:0], v_s2};
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ld_q[0]    <= l_s2;
			zerod_q[0] <= zero_s2;
			fed_q[0]   <= fe_s2;
			for (int i = 1; i < QUO_W; i++) begin
				ld_q[i]    <= ld_q[i-1];
				zerod_q[i] <= zerod_q[i-1];
				fed_q[i]   <= fed_q[i-1];
			end
		end
	end

	// output stage: threshold tests
	logic [7:0]  sat, hue, lt;
	logic [15:0] l16, lo_prod, hi_prod;
	logic        skin;

	always_comb begin
		sat     = zerod_q[QUO_W-1] ? 8'd0 : sat_q;
		hue     = zerod_q[QUO_W-1] ? 8'd0 : hue_q;
		lt      = ld_q[QUO_W-1];
		l16     = 16'({lt, 4'b0});
		lo_prod = 16'(cfg_q.ratio_lo) * 16'(sat);
		hi_prod = 16'(cfg_q.ratio_hi) * 16'(sat);
		skin    = (sat >= cfg_q.min_sat) && (l16 > lo_prod) && (l16 < hi_prod)
			&& ((hue <= cfg_q.hue_low) || (hue >= cfg_q.hue_high));
	end

	logic skin_q, fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= vd_q[QUO_W-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			skin_q <= skin;
			fe_q   <= fed_q[QUO_W-1];
		end
	end

	assign mask.valid         = out_valid_q;
	assign mask.is_skin       = skin_q;
	assign mask.mask_value    = skin_q ? 8'd255 : 8'd0;
	assign mask.frame_end_out = fe_q;
endmodule
`default_nettype wire

// File: rtl/core/hspc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module hspc_div
	import hspc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num_i,
	input  wire logic [DEN_W-1:0] den_i,
	output logic      [QUO_W-1:0] quo_o
);
	// caller guarantees num_i < den_i << QUO_W
	logic [NUM_W-1:0] rem_r [0:QUO_W-1];
	logic [DEN_W-1:0] den_r [0:QUO_W-1];
	logic [QUO_W-1:0] quo_r [0:QUO_W-1];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [NUM_W-1:0] rin;
		logic [DEN_W-1:0] din;
		logic [QUO_W-1:0] qin;
		logic [NUM_W:0]   dsh;
		logic             ge;
		if (k == 0) begin : g_first
			assign rin = num_i;
			assign din = den_i;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_r[k-1];
			assign din = den_r[k-1];
			assign qin = quo_r[k-1];
		end
		assign dsh = (NUM_W+1)'(din) << (QUO_W-1-k);
		assign ge  = (NUM_W+1)'(rin) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_r[k] <= ge ? rin - dsh[NUM_W-1:0] : rin;
				den_r[k] <= din;
				quo_r[k] <= qin | (ge ? QUO_W'(1) << (QUO_W-1-k) : '0);
			end
		end
	end

	assign quo_o = quo_r[QUO_W-1];
endmodule
`default_nettype wire

// File: rtl/core/hspc_checker.sv
// Port-level checks for the skin pixel classifier, bound to the top level.
`default_nettype none
module hspc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       pix_ready,
	input wire logic       mask_valid,
	input wire logic       mask_ready,
	input wire logic [7:0] mask_value,
	input wire logic       is_skin,
	input wire logic       frame_end_out,
	input wire logic       cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mask_valid && !mask_ready |=> mask_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		mask_valid && !mask_ready |=> $stable(mask_value) && $stable(frame_end_out))
		else $error("stalled result changed");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		mask_valid |-> (is_skin && mask_value == 8'd255)
			|| (!is_skin && mask_value == 8'd0))
		else $error("mask value disagrees with skin flag");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready == (!mask_valid || mask_ready))
		else $error("pipe stalls without a blocked result");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("register port not ready");
endmodule

bind hls_skin_pixel_classifier_unit hspc_checker u_hspc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pix_ready(pixel.ready),
	.mask_valid(mask.valid),
	.mask_ready(mask.ready),
	.mask_value(mask.mask_value),
	.is_skin(mask.is_skin),
	.frame_end_out(mask.frame_end_out),
	.cfg_ready(cfg.ready)
);
`default_nettype wire

// File: tb/tb_hls_skin_pixel_classifier_unit.sv
// Self-checking testbench for the skin pixel classifier: random BGR pixels, register sweeps.
`timescale 1ns / 100ps
module tb_hls_skin_pixel_classifier_unit
	import hspc_pkg::*;
;
	// index past the register list, writes to it are dropped
	localparam cfg_idx_t CFG_IDX_NONE = 3'd7;

	typedef struct packed {
		logic [7:0] mask_value;
		logic       is_skin;
		logic       frame_end_out;
	} mask_res_t;

	class mask_scoreboard;
		mask_res_t  pending_masks[$];
		cfg_regs_t  regs;
		int         mismatches;

		function void load_reset();
			regs.min_sat  = RST_MIN_SAT;
			regs.hue_low  = RST_HUE_LOW;
			regs.hue_high = RST_HUE_HIGH;
			regs.ratio_lo = RST_RATIO_LO;
			regs.ratio_hi = RST_RATIO_HI;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [7:0] val);
			case (idx)
				CFG_MIN_SAT:  regs.min_sat  = val;
				CFG_HUE_LOW:  regs.hue_low  = val;
				CFG_HUE_HIGH: regs.hue_high = val;
				CFG_RATIO_LO: regs.ratio_lo = val;
				CFG_RATIO_HI: regs.ratio_hi = val;
				default: ;
			endcase
		endfunction

		function int rdiv(int num, int den);
			return (2 * num + den) / (2 * den);
		endfunction

		// classify one pixel and queue the expected mask
		function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fe);
			int mx, mn, d, sm, lig, sat, hue, num, base, x;
			bit skin;
			mask_res_t res;
			mx = r; mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			sm = mx + mn;
			lig = (sm + 1) >> 1;
			if (d == 0) begin
				hue = 0;
				sat = 0;
			end else begin
				sat = (sm < 255) ? rdiv(255 * d, sm) : rdiv(255 * d, 510 - sm);
				if (mx == r) begin
					num = int'(g) - int'(b); base = 0;
				end else if (mx == g) begin
					num = int'(b) - int'(r); base = 60;
				end else begin
					num = int'(r) - int'(g); base = 120;
				end
				x = 30 * num + base * d;
				if (x < 0) x += 180 * d;
				hue = rdiv(x, d);
			end
			skin = (sat >= regs.min_sat) && (16 * lig > regs.ratio_lo * sat)
				&& (16 * lig < regs.ratio_hi * sat)
				&& (hue <= regs.hue_low || hue >= regs.hue_high);
			res.mask_value = skin ? 8'd255 : 8'd0;
			res.is_skin = skin;
			res.frame_end_out = fe;
			pending_masks.push_back(res);
		endfunction

		function void check_mask(mask_res_t got);
			mask_res_t exp_m;
			if (pending_masks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected mask transaction %p", got);
				return;
			end
			exp_m = pending_masks.pop_front();
			if (got !== exp_m) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mask mismatch: expected %p got %p", exp_m, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   no_idle = 1'b0;
	mask_scoreboard sb;

	hspc_pix_if  pixel();
	hspc_mask_if mask();
	hspc_cfg_if  cfg();

	hls_skin_pixel_classifier_unit dut (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .mask(mask), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		pixel.valid = 1'b0; pixel.blue = '0; pixel.green = '0; pixel.red = '0;
		pixel.frame_end = 1'b0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		mask.ready = 1'b0;
	end

	// receiver with random stall bursts
	initial begin : mask_sink
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (mask.valid && mask.ready) sb.check_mask({mask.mask_value, mask.is_skin,
				mask.frame_end_out});
			if (!no_idle && $urandom_range(0, 5) == 0 && stall == 0)
				stall = $urandom_range(1, 7);
			if (stall > 0) begin
				stall--;
				mask.ready <= 1'b0;
			end else mask.ready <= 1'b1;
		end
	end

	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fe);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			pixel.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.blue <= b; pixel.green <= g; pixel.red <= r; pixel.frame_end <= fe;
		do @(posedge clk); while (!pixel.ready);
		sb.note_pixel(b, g, r, fe);
	endtask

	task automatic drain();
		pixel.valid <= 1'b0;
		while (sb.pending_masks.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [7:0] val);
		cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, val);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// skin-like pixels often enough to hit both outcomes
	task automatic random_pixels(int n);
		logic [7:0] b, g, r;
		repeat (n) begin
			if ($urandom_range(0, 1)) begin
				r = 8'($urandom_range(90, 255));
				g = 8'($urandom_range(r / 3, r));
				b = 8'($urandom_range(0, g));
			end else begin
				r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
			end
			send_pixel(b, g, r, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : stimulus
		logic [7:0] rgb [0:19][0:2];
		sb = new();
		sb.load_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// gray, pure primaries, extremes, hue wrap, skin tones
		rgb = '{'{0,0,0}, '{255,255,255}, '{128,128,128}, '{0,0,255}, '{0,255,0},
			'{255,0,0}, '{255,255,0}, '{0,255,255}, '{255,0,255}, '{1,0,255},
			'{0,1,255}, '{90,120,200}, '{60,100,180}, '{120,150,230}, '{254,255,255},
			'{0,0,1}, '{127,127,128}, '{100,140,220}, '{40,60,120}, '{170,190,240}};
		foreach (rgb[i]) send_pixel(rgb[i][0], rgb[i][1], rgb[i][2], i[0]);
		random_pixels(80);
		drain();
		// extremes of every register
		write_cfg(CFG_MIN_SAT, 8'd0);
		write_cfg(CFG_HUE_LOW, 8'd180);
		write_cfg(CFG_HUE_HIGH, 8'd0);
		write_cfg(CFG_RATIO_LO, 8'd0);
		write_cfg(CFG_RATIO_HI, 8'd255);
		write_cfg(CFG_IDX_NONE, 8'd99);
		random_pixels(80);
		drain();
		write_cfg(CFG_MIN_SAT, 8'd255);
		write_cfg(CFG_HUE_LOW, 8'd0);
		write_cfg(CFG_HUE_HIGH, 8'd180);
		write_cfg(CFG_RATIO_LO, 8'd255);
		write_cfg(CFG_RATIO_HI, 8'd0);
		random_pixels(60);
		drain();
		repeat (3) begin
			write_cfg(CFG_MIN_SAT, 8'($urandom_range(0, 120)));
			write_cfg(CFG_HUE_LOW, 8'($urandom_range(0, 40)));
			write_cfg(CFG_HUE_HIGH, 8'($urandom_range(140, 180)));
			write_cfg(CFG_RATIO_LO, 8'($urandom_range(0, 16)));
			write_cfg(CFG_RATIO_HI, 8'($urandom_range(16, 96)));
			random_pixels(50);
			drain();
		end
		no_idle = 1'b1;
		random_pixels(40);
		drain();
		if (sb.mismatches == 0 && sb.pending_masks.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
